### sv/source_text_tokenizer_macros.svh
// Assertion macros used by the tokenizer checker.
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define STT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while in reset.
`define STT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/stt_pkg.sv
// Types, codes, character constants and classification functions for the tokenizer.
package stt_pkg;

    localparam int STT_QUEUE_DEPTH = 4;
    localparam int PUNCT_COUNT     = 17;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_ID   = 3'd1,
        MODE_NUM  = 3'd2,
        MODE_STR  = 3'd3,
        MODE_ESC  = 3'd4,
        MODE_ERR  = 3'd5
    } t_mode;

    typedef logic [4:0] t_kind;
    typedef logic [2:0] t_err;

    localparam t_kind KIND_ID     = 5'd0;
    localparam t_kind KIND_NUM    = 5'd1;
    localparam t_kind KIND_STR    = 5'd2;
    localparam t_kind KIND_PUNCT0 = 5'd3;
    localparam t_kind KIND_END    = 5'd20;
    localparam t_kind KIND_ERR    = 5'd21;

    localparam t_err ERR_NONE       = 3'd0;
    localparam t_err ERR_UNEXPECTED = 3'd1;
    localparam t_err ERR_NUMBER     = 3'd2;
    localparam t_err ERR_STRING     = 3'd3;
    localparam t_err ERR_ESCAPE     = 3'd4;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // = ; ( ) { } [ ] , : + - * / % ^ >
    localparam logic [7:0] PUNCT_CHARS [PUNCT_COUNT] = '{
        8'h3D, 8'h3B, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h2C,
        8'h3A, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h5E, 8'h3E
    };

    typedef struct packed {
        t_kind      token_kind;
        logic [7:0] value_byte;
        logic       has_byte;
        logic       first_of_token;
        logic       last_of_token;
        t_err       error_code;
    } t_tok;

    typedef struct packed {
        logic two;
        t_tok a;
        t_tok b;
    } t_pair;

    typedef struct packed {
        logic  hit;
        t_kind kind;
    } t_punct;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic t_punct punct_lookup(input logic [7:0] c);
        t_punct r;
        r = '0;
        for (int k = 0; k < PUNCT_COUNT; k++) begin
            if (PUNCT_CHARS[k] == c) begin
                r.hit  = 1'b1;
                r.kind = KIND_PUNCT0 + 5'(k);
            end
        end
        return r;
    endfunction

    function automatic t_tok mk_tok(input t_kind kind, input logic [7:0] val,
                                    input logic has, input logic first,
                                    input logic last, input t_err err);
        t_tok t;
        t.token_kind     = kind;
        t.value_byte     = val;
        t.has_byte       = has;
        t.first_of_token = first;
        t.last_of_token  = last;
        t.error_code     = err;
        return t;
    endfunction

endpackage

### sv/stt_if.sv
// Valid/ready channel interfaces for source bytes and token items.
interface stt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, text_byte, end_of_text, input ready);
    modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface stt_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] token_kind;
    logic [7:0] value_byte;
    logic       has_byte;
    logic       first_of_token;
    logic       last_of_token;
    logic [2:0] error_code;

    modport source (output valid, token_kind, value_byte, has_byte, first_of_token,
                    last_of_token, error_code, input ready);
    modport sink   (input valid, token_kind, value_byte, has_byte, first_of_token,
                    last_of_token, error_code, output ready);
endinterface

### sv/stt_queue.sv
// Short FIFO of result pairs between the scanner and the output stage.
module stt_queue import stt_pkg::*; #(
    parameter int DEPTH = STT_QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_pair i_push_data,
    output logic  o_ready,
    output logic  o_valid,
    output t_pair o_data,
    input  logic  i_pop
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_pair          r_mem [DEPTH];
    logic [PW-1:0]  r_wp, n_wp;
    logic [PW-1:0]  r_rp, n_rp;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           do_push, do_pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!do_push && do_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

### sv/stt_front.sv
// Scanner: classifies each source byte, tracks token mode and forms result pairs.
module stt_front import stt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stt_in_if.sink      i_text,
    input  logic        i_q_ready,
    output logic        o_push,
    output t_pair       o_push_data
);

    t_mode      r_mode, n_mode;
    logic [7:0] r_held, n_held;
    logic       r_hvalid, n_hvalid;
    logic       r_hfirst, n_hfirst;
    logic       r_point, n_point;

    logic [7:0] c;
    logic       accept, eot;
    logic       sp, al, dg, us, qt, bs, pt, idc;
    t_punct     pu;
    t_kind      tok_kind;
    logic [7:0] push_val;
    t_tok       close_item, held_item, end_item;

    t_mode      idle_mode;
    logic       idle_emit, idle_hvalid, idle_hfirst;
    t_tok       idle_item;

    logic       emit0, emit1;
    t_tok       o0, o1;

    assign c      = i_text.text_byte;
    assign i_text.ready = i_q_ready;
    assign accept = i_text.valid && i_q_ready;
    assign eot    = i_text.end_of_text || (c == CH_NUL);

    assign sp  = is_space(c);
    assign al  = is_alpha(c);
    assign dg  = is_digit(c);
    assign us  = (c == CH_UNDER);
    assign qt  = (c == CH_QUOTE);
    assign bs  = (c == CH_BSLASH);
    assign pt  = (c == CH_POINT);
    assign idc = al || dg || us;
    assign pu  = punct_lookup(c);

    assign tok_kind = (r_mode == MODE_NUM) ? KIND_NUM :
                      ((r_mode == MODE_STR) || (r_mode == MODE_ESC)) ? KIND_STR : KIND_ID;
    assign push_val = (r_mode != MODE_ESC) ? c :
                      (c == CH_N) ? CH_NL : (c == CH_T) ? CH_TAB : c;

    assign close_item = r_hvalid ? mk_tok(tok_kind, r_held, 1'b1, r_hfirst, 1'b1, ERR_NONE)
                                 : mk_tok(tok_kind, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
    assign held_item  = mk_tok(tok_kind, r_held, 1'b1, r_hfirst, 1'b0, ERR_NONE);
    assign end_item   = mk_tok(KIND_END, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);

    // Byte handled as the opening character of a new token
    always_comb begin
        idle_mode   = MODE_IDLE;
        idle_emit   = 1'b0;
        idle_item   = end_item;
        idle_hvalid = 1'b0;
        idle_hfirst = 1'b0;
        if (sp) begin
            idle_mode = MODE_IDLE;
        end else if (al || us) begin
            idle_mode   = MODE_ID;
            idle_hvalid = 1'b1;
            idle_hfirst = 1'b1;
        end else if (dg) begin
            idle_mode   = MODE_NUM;
            idle_hvalid = 1'b1;
            idle_hfirst = 1'b1;
        end else if (qt) begin
            idle_mode   = MODE_STR;
            idle_hfirst = 1'b1;
        end else if (pu.hit) begin
            idle_emit = 1'b1;
            idle_item = mk_tok(pu.kind, c, 1'b1, 1'b1, 1'b1, ERR_NONE);
        end else begin
            idle_mode = MODE_ERR;
            idle_emit = 1'b1;
            idle_item = mk_tok(KIND_ERR, 8'h00, 1'b0, 1'b1, 1'b1, ERR_UNEXPECTED);
        end
    end

    // Next mode
    always_comb begin
        n_mode  = r_mode;
        n_point = r_point;
        if (eot) begin
            n_mode  = MODE_IDLE;
            n_point = 1'b0;
        end else begin
            unique case (r_mode)
                MODE_ERR: begin
                    n_mode = MODE_ERR;
                end
                MODE_STR: begin
                    if (qt) begin
                        n_mode = MODE_IDLE;
                    end else if (bs) begin
                        n_mode = MODE_ESC;
                    end
                end
                MODE_ESC: begin
                    n_mode = MODE_STR;
                end
                MODE_ID: begin
                    if (!idc) begin
                        n_mode = idle_mode;
                    end
                end
                MODE_NUM: begin
                    if (pt) begin
                        if (r_point) begin
                            n_mode = MODE_ERR;
                        end else begin
                            n_point = 1'b1;
                        end
                    end else if (!dg) begin
                        n_mode  = idle_mode;
                        n_point = 1'b0;
                    end
                end
                default: begin
                    n_mode = idle_mode;
                    if (dg) begin
                        n_point = 1'b0;
                    end
                end
            endcase
        end
    end

    // Held byte and results
    always_comb begin
        logic do_push;
        logic do_cidle;
        do_push  = 1'b0;
        do_cidle = 1'b0;
        emit0    = 1'b0;
        emit1    = 1'b0;
        o0       = end_item;
        o1       = end_item;
        n_held   = r_held;
        n_hvalid = r_hvalid;
        n_hfirst = r_hfirst;
        if (eot) begin
            n_hvalid = 1'b0;
            n_hfirst = 1'b0;
            unique case (r_mode)
                MODE_ID, MODE_NUM: begin
                    emit0 = 1'b1;
                    o0    = close_item;
                    emit1 = 1'b1;
                    o1    = end_item;
                end
                MODE_STR: begin
                    emit0 = 1'b1;
                    o0    = mk_tok(KIND_ERR, 8'h00, 1'b0, 1'b1, 1'b1, ERR_STRING);
                end
                MODE_ESC: begin
                    emit0 = 1'b1;
                    o0    = mk_tok(KIND_ERR, 8'h00, 1'b0, 1'b1, 1'b1, ERR_ESCAPE);
                end
                MODE_ERR: begin
                    emit0 = 1'b0;
                end
                default: begin
                    emit0 = 1'b1;
                    o0    = end_item;
                end
            endcase
        end else begin
            unique case (r_mode)
                MODE_ERR: begin
                    emit0 = 1'b0;
                end
                MODE_STR: begin
                    if (qt) begin
                        emit0    = 1'b1;
                        o0       = close_item;
                        n_hvalid = 1'b0;
                        n_hfirst = 1'b0;
                    end else if (!bs) begin
                        do_push = 1'b1;
                    end
                end
                MODE_ESC: begin
                    do_push = 1'b1;
                end
                MODE_ID: begin
                    if (idc) begin
                        do_push = 1'b1;
                    end else begin
                        do_cidle = 1'b1;
                    end
                end
                MODE_NUM: begin
                    if (dg) begin
                        do_push = 1'b1;
                    end else if (pt) begin
                        if (r_point) begin
                            emit0    = 1'b1;
                            o0       = mk_tok(KIND_ERR, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NUMBER);
                            n_hvalid = 1'b0;
                            n_hfirst = 1'b0;
                        end else begin
                            do_push = 1'b1;
                        end
                    end else begin
                        do_cidle = 1'b1;
                    end
                end
                default: begin
                    emit0    = idle_emit;
                    o0       = idle_item;
                    n_held   = c;
                    n_hvalid = idle_hvalid;
                    n_hfirst = idle_hfirst;
                end
            endcase
        end
        if (do_push) begin
            emit0    = r_hvalid;
            o0       = held_item;
            n_hfirst = r_hvalid ? 1'b0 : r_hfirst;
            n_held   = push_val;
            n_hvalid = 1'b1;
        end
        if (do_cidle) begin
            emit0    = 1'b1;
            o0       = close_item;
            emit1    = idle_emit;
            o1       = idle_item;
            n_held   = c;
            n_hvalid = idle_hvalid;
            n_hfirst = idle_hfirst;
        end
    end

    assign o_push        = accept && emit0;
    assign o_push_data.two = emit1;
    assign o_push_data.a   = o0;
    assign o_push_data.b   = o1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_hvalid <= 1'b0;
            r_hfirst <= 1'b0;
            r_point  <= 1'b0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_hvalid <= n_hvalid;
            r_hfirst <= n_hfirst;
            r_point  <= n_point;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

endmodule

### sv/stt_back.sv
// Output stage: splits queued result pairs into single token items on a registered port.
module stt_back import stt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_pair       i_q_data,
    output logic        o_q_pop,
    stt_out_if.source   o_tok
);

    logic r_out_valid, n_out_valid;
    logic r_idx, n_idx;
    t_tok r_out;
    logic load;

    assign load    = (!r_out_valid || o_tok.ready) && i_q_valid;
    assign o_q_pop = load && (r_idx || !i_q_data.two);

    always_comb begin
        n_out_valid = r_out_valid;
        n_idx       = r_idx;
        if (load) begin
            n_out_valid = 1'b1;
            n_idx       = i_q_data.two && !r_idx;
        end else if (o_tok.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= r_idx ? i_q_data.b : i_q_data.a;
        end
    end

    assign o_tok.valid          = r_out_valid;
    assign o_tok.token_kind     = r_out.token_kind;
    assign o_tok.value_byte     = r_out.value_byte;
    assign o_tok.has_byte       = r_out.has_byte;
    assign o_tok.first_of_token = r_out.first_of_token;
    assign o_tok.last_of_token  = r_out.last_of_token;
    assign o_tok.error_code     = r_out.error_code;

endmodule

### sv/source_text_tokenizer.sv
// Top level of the streaming source text tokenizer.
//
//  channel  | dir | payload                                          | transaction
//  i_text   | in  | text_byte, end_of_text                           | valid & ready
//  o_tok    | out | token_kind, value_byte, has_byte, first_of_token, | valid & ready
//           |     | last_of_token, error_code                        |
//
// The scanner takes one source byte per cycle while the result queue has room and scans it in that cycle.
// Each byte yields zero, one or two token items; each item is a transaction of its own at o_tok.
// i_text stalls only when the result queue (QUEUE_DEPTH pairs) is full.
// Synchronous active-low reset returns the scanner to idle and empties the queue.
// The first item of a byte passes through the result queue and the output register before it leaves o_tok.
module source_text_tokenizer import stt_pkg::*; #(
    parameter int QUEUE_DEPTH = STT_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stt_in_if.sink      i_text,
    stt_out_if.source   o_tok
);

    logic  q_ready;
    logic  push;
    t_pair push_data;
    logic  q_valid;
    t_pair q_data;
    logic  q_pop;

    stt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_text      (i_text),
        .i_q_ready   (q_ready),
        .o_push      (push),
        .o_push_data (push_data)
    );

    stt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_ready     (q_ready),
        .o_valid     (q_valid),
        .o_data      (q_data),
        .i_pop       (q_pop)
    );

    stt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_tok     (o_tok)
    );

endmodule

### sv/stt_checker.sv
// Port-level checks on token items, bound to the tokenizer top level.
`include "source_text_tokenizer_macros.svh"

module stt_checker import stt_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [4:0] i_token_kind,
    input logic       i_has_byte,
    input logic       i_first_of_token,
    input logic       i_last_of_token,
    input logic [2:0] i_error_code
);

    `STT_ASSERT_NEXT(a_valid_hold, i_out_valid && !i_out_ready, i_out_valid, "token item dropped while stalled")
    `STT_ASSERT_IMPL(a_err_shape, i_out_valid && (i_token_kind == KIND_ERR), !i_has_byte && i_first_of_token && i_last_of_token && (i_error_code != ERR_NONE), "malformed error item")
    `STT_ASSERT_IMPL(a_code_clean, i_out_valid && (i_token_kind != KIND_ERR), i_error_code == ERR_NONE, "error code on a non-error item")
    `STT_ASSERT_IMPL(a_single_item, i_out_valid && (i_token_kind >= KIND_PUNCT0) && (i_token_kind <= KIND_END), i_first_of_token && i_last_of_token, "punctuation or end token split over items")

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_tok.valid),
    .i_out_ready      (o_tok.ready),
    .i_token_kind     (o_tok.token_kind),
    .i_has_byte       (o_tok.has_byte),
    .i_first_of_token (o_tok.first_of_token),
    .i_last_of_token  (o_tok.last_of_token),
    .i_error_code     (o_tok.error_code)
);

### tb/source_text_tokenizer_tb.sv
// Self-checking testbench for the streaming source text tokenizer.
`timescale 1ns / 100ps

module source_text_tokenizer_tb;
    import stt_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 1440;

    logic i_clk;
    logic i_rst_n;

    stt_in_if  u_text_if ();
    stt_out_if u_tok_if ();

    source_text_tokenizer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (u_text_if),
        .o_tok   (u_tok_if)
    );

    t_tok       tokens_due[$];
    int         mismatches    = 0;
    int         scanned_items = 0;
    int         src_gap_pct   = 30;
    int         hold_asked    = 0;
    int         hold_done     = 0;

    t_mode      scan_mode  = MODE_IDLE;
    logic [7:0] held_ch    = 8'h00;
    logic       held_ok    = 1'b0;
    logic       held_first = 1'b0;
    logic       point_seen = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic blank_char(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic letter_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic void put_tok(input t_kind k, input logic [7:0] v, input logic has,
                                    input logic first, input logic last, input t_err e);
        t_tok t;
        t.token_kind     = k;
        t.value_byte     = v;
        t.has_byte       = has;
        t.first_of_token = first;
        t.last_of_token  = last;
        t.error_code     = e;
        tokens_due.push_back(t);
    endfunction

    function automatic void hold_byte(input t_kind k, input logic [7:0] c);
        if (held_ok) begin
            put_tok(k, held_ch, 1'b1, held_first, 1'b0, ERR_NONE);
            held_first = 1'b0;
        end
        held_ch = c;
        held_ok = 1'b1;
    endfunction

    function automatic void close_tok(input t_kind k);
        if (held_ok) begin
            put_tok(k, held_ch, 1'b1, held_first, 1'b1, ERR_NONE);
        end else begin
            put_tok(k, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
        end
        held_ok    = 1'b0;
        held_first = 1'b0;
    endfunction

    function automatic void raise_err(input t_err e);
        held_ok    = 1'b0;
        held_first = 1'b0;
        scan_mode  = MODE_ERR;
        put_tok(KIND_ERR, 8'h00, 1'b0, 1'b1, 1'b1, e);
    endfunction

    function automatic void start_from_idle(input logic [7:0] c);
        scan_mode = MODE_IDLE;
        if (blank_char(c)) return;
        if (letter_char(c) || c == CH_UNDER) begin
            scan_mode  = MODE_ID;
            held_ok    = 1'b0;
            held_first = 1'b1;
            hold_byte(KIND_ID, c);
            return;
        end
        if (digit_char(c)) begin
            scan_mode  = MODE_NUM;
            point_seen = 1'b0;
            held_ok    = 1'b0;
            held_first = 1'b1;
            hold_byte(KIND_NUM, c);
            return;
        end
        if (c == CH_QUOTE) begin
            scan_mode  = MODE_STR;
            held_ok    = 1'b0;
            held_first = 1'b1;
            return;
        end
        for (int k = 0; k < PUNCT_COUNT; k++) begin
            if (PUNCT_CHARS[k] == c) begin
                put_tok(KIND_PUNCT0 + 5'(k), c, 1'b1, 1'b1, 1'b1, ERR_NONE);
                return;
            end
        end
        raise_err(ERR_UNEXPECTED);
    endfunction

    function automatic void scan_byte(input logic [7:0] c, input logic eot);
        logic [7:0] ch;
        ch = c;
        if (eot || c == CH_NUL) begin
            case (scan_mode)
                MODE_ID: begin
                    close_tok(KIND_ID);
                    put_tok(KIND_END, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
                end
                MODE_NUM: begin
                    close_tok(KIND_NUM);
                    put_tok(KIND_END, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
                end
                MODE_STR: put_tok(KIND_ERR, 8'h00, 1'b0, 1'b1, 1'b1, ERR_STRING);
                MODE_ESC: put_tok(KIND_ERR, 8'h00, 1'b0, 1'b1, 1'b1, ERR_ESCAPE);
                MODE_ERR: ;
                default:  put_tok(KIND_END, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
            endcase
            scan_mode  = MODE_IDLE;
            held_ch    = 8'h00;
            held_ok    = 1'b0;
            held_first = 1'b0;
            point_seen = 1'b0;
            return;
        end
        case (scan_mode)
            MODE_ERR: ;
            MODE_STR: begin
                if (c == CH_QUOTE) begin
                    close_tok(KIND_STR);
                    scan_mode = MODE_IDLE;
                end else if (c == CH_BSLASH) begin
                    scan_mode = MODE_ESC;
                end else begin
                    hold_byte(KIND_STR, c);
                end
            end
            MODE_ESC: begin
                if (c == CH_N) ch = CH_NL;
                else if (c == CH_T) ch = CH_TAB;
                scan_mode = MODE_STR;
                hold_byte(KIND_STR, ch);
            end
            MODE_ID: begin
                if (letter_char(c) || digit_char(c) || c == CH_UNDER) begin
                    hold_byte(KIND_ID, c);
                end else begin
                    close_tok(KIND_ID);
                    start_from_idle(c);
                end
            end
            MODE_NUM: begin
                if (digit_char(c)) begin
                    hold_byte(KIND_NUM, c);
                end else if (c == CH_POINT) begin
                    if (point_seen) begin
                        raise_err(ERR_NUMBER);
                    end else begin
                        point_seen = 1'b1;
                        hold_byte(KIND_NUM, c);
                    end
                end else begin
                    close_tok(KIND_NUM);
                    point_seen = 1'b0;
                    start_from_idle(c);
                end
            end
            default: start_from_idle(c);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : check_tokens
        t_tok got;
        t_tok want;
        if (i_rst_n) begin
            if (u_tok_if.valid && u_tok_if.ready) begin
                got.token_kind     = u_tok_if.token_kind;
                got.value_byte     = u_tok_if.value_byte;
                got.has_byte       = u_tok_if.has_byte;
                got.first_of_token = u_tok_if.first_of_token;
                got.last_of_token  = u_tok_if.last_of_token;
                got.error_code     = u_tok_if.error_code;
                if (tokens_due.size() == 0) begin
                    report_mismatch("token with nothing pending, kind", got.token_kind, -1);
                end else begin
                    want = tokens_due.pop_front();
                    if (got.token_kind != want.token_kind)
                        report_mismatch("token_kind", got.token_kind, want.token_kind);
                    if (got.value_byte != want.value_byte)
                        report_mismatch("value_byte", got.value_byte, want.value_byte);
                    if (got.has_byte != want.has_byte)
                        report_mismatch("has_byte", got.has_byte, want.has_byte);
                    if (got.first_of_token != want.first_of_token)
                        report_mismatch("first_of_token", got.first_of_token,
                                        want.first_of_token);
                    if (got.last_of_token != want.last_of_token)
                        report_mismatch("last_of_token", got.last_of_token,
                                        want.last_of_token);
                    if (got.error_code != want.error_code)
                        report_mismatch("error_code", got.error_code, want.error_code);
                end
            end
            if (u_text_if.valid && u_text_if.ready)
                scan_byte(u_text_if.text_byte, u_text_if.end_of_text);
        end
    end

    function automatic int pause_len();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    initial begin : token_sink
        int stall_left;
        int pct;
        int tick;
        stall_left = 0;
        pct        = 0;
        tick       = 0;
        u_tok_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (tick % 256 == 0) begin
                case ($urandom_range(0, 2))
                    0:       pct = 0;
                    1:       pct = 10;
                    default: pct = 35;
                endcase
            end
            if (stall_left > 0) begin
                u_tok_if.ready <= 1'b0;
                stall_left--;
            end else if (hold_asked != hold_done) begin
                hold_done++;
                u_tok_if.ready <= 1'b0;
                stall_left = HOLD_CYCLES - 1;
            end else if (pct != 0 && $urandom_range(0, 99) < pct) begin
                u_tok_if.ready <= 1'b0;
                stall_left = pause_len() - 1;
            end else begin
                u_tok_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("source_text_tokenizer_tb: done, errors");
        $finish;
    end

    // Enter and leave at a falling edge; return once the transaction is taken.
    task automatic send_item(input logic [7:0] b, input logic e);
        int gap;
        gap = 0;
        if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) gap = pause_len();
        scanned_items++;
        if (gap != 0) begin
            u_text_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        u_text_if.valid       <= 1'b1;
        u_text_if.text_byte   <= b;
        u_text_if.end_of_text <= e;
        do @(posedge i_clk); while (!u_text_if.ready);
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    endtask

    function automatic logic [7:0] word_char(input bit lead);
        int r;
        r = $urandom_range(0, lead ? 52 : 62);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r == 52) return CH_UNDER;
        return 8'("0" + r - 53);
    endfunction

    task automatic send_word();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) send_item(word_char(i == 0), 1'b0);
    endtask

    task automatic send_number();
        int n;
        int pt;
        n  = $urandom_range(1, 6);
        pt = ($urandom_range(0, 2) == 0) ? $urandom_range(1, n) : 0;
        for (int i = 0; i < n; i++) begin
            send_item(8'("0" + $urandom_range(0, 9)), 1'b0);
            if (i + 1 == pt) send_item(CH_POINT, 1'b0);
        end
        if ($urandom_range(0, 19) == 0) send_item(CH_POINT, 1'b0);
    endtask

    task automatic send_quoted();
        int n;
        logic [7:0] b;
        n = $urandom_range(0, 8);
        send_item(CH_QUOTE, 1'b0);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 15) begin
                send_item(CH_BSLASH, 1'b0);
                case ($urandom_range(0, 4))
                    0:       b = CH_N;
                    1:       b = CH_T;
                    2:       b = CH_QUOTE;
                    3:       b = CH_BSLASH;
                    default: b = 8'($urandom_range(1, 255));
                endcase
            end else begin
                b = 8'($urandom_range(1, 255));
                if (b == CH_QUOTE || b == CH_BSLASH) b = CH_UNDER;
            end
            send_item(b, 1'b0);
        end
        if ($urandom_range(0, 19) != 0) send_item(CH_QUOTE, 1'b0);
    endtask

    task automatic test_tokens();
        src_gap_pct = 30;
        send_text("a_9(7.5+\"x\\n\"\"\"");
        send_item(8'h41, 1'b1);
        send_text("42");
        send_item(8'h00, 1'b1);
    endtask

    task automatic test_errors();
        send_text("Z1 1.2.");
        send_item(8'h00, 1'b1);
        send_text("\"\\");
        send_item(CH_NUL, 1'b0);
        send_text("\"a");
        send_item(8'hFF, 1'b1);
        send_item(CH_POINT, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(CH_NUL, 1'b0);
    endtask

    task automatic test_backpressure();
        src_gap_pct = 0;
        u_text_if.valid <= 1'b0;
        @(posedge i_clk);
        hold_asked++;
        @(negedge i_clk);
        for (int i = 0; i < 14; i++) begin
            send_word();
            send_item(PUNCT_CHARS[i % PUNCT_COUNT], 1'b0);
        end
        send_item(8'h00, 1'b1);
    endtask

    task automatic test_random();
        int r;
        int goal;
        int pace_at;
        goal    = scanned_items + RANDOM_ITEMS;
        pace_at = scanned_items;
        while (scanned_items < goal) begin
            if (scanned_items >= pace_at) begin
                case ($urandom_range(0, 2))
                    0:       src_gap_pct = 0;
                    1:       src_gap_pct = 15;
                    default: src_gap_pct = 50;
                endcase
                pace_at = scanned_items + 200;
            end
            r = $urandom_range(0, 99);
            if (r < 25)       send_word();
            else if (r < 43)  send_number();
            else if (r < 58)  send_quoted();
            else if (r < 76)  send_item(PUNCT_CHARS[$urandom_range(0, PUNCT_COUNT - 1)], 1'b0);
            else if (r < 87) begin
                r = $urandom_range(8, 13);
                send_item((r == 8) ? 8'h20 : 8'(r), 1'b0);
            end
            else if (r < 93)  send_item(8'($urandom_range(0, 255)), 1'b0);
            else if (r < 97)  send_item(8'($urandom_range(0, 255)), 1'b1);
            else              send_item(CH_NUL, 1'b0);
        end
        send_item(8'h00, 1'b1);
    endtask

    initial begin
        i_rst_n               = 1'b0;
        u_text_if.valid       = 1'b0;
        u_text_if.text_byte   = 8'h00;
        u_text_if.end_of_text = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_tokens();
        test_errors();
        test_backpressure();
        test_random();
        u_text_if.valid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("source_text_tokenizer_tb: done, clean");
        end else begin
            $display("source_text_tokenizer_tb: done, errors");
        end
        $finish;
    end

endmodule
